FILE: rtl/core/iws_pkg.sv
package iws_pkg;

    localparam int WINDOW_MAX = 64;
    localparam int TIME_BITS  = 32;
    localparam int PTR_W      = $clog2(WINDOW_MAX);
    localparam int CNT_W      = $clog2(WINDOW_MAX + 1);
    localparam int SUM_W      = TIME_BITS + PTR_W;
    localparam int DCNT_W     = $clog2(SUM_W);
    localparam int ADDR_W     = 3;
    localparam int DATA_W     = 32;
    localparam int OPC_W      = 2;

    // Register index as decoded from paddr[ADDR_W-1:2].
    localparam logic [ADDR_W-3:0] REG_WINDOW_LEN = '0;
    localparam logic [CNT_W-1:0]  WINDOW_LEN_RESET = CNT_W'(WINDOW_MAX);

    typedef enum logic [OPC_W-1:0] {
        OP_START = 2'd0,
        OP_STOP  = 2'd1,
        OP_QUERY = 2'd2
    } opcode_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

FILE: rtl/core/iws_if.sv
interface iws_in_if;
    logic                          valid;
    logic                          ready;
    logic [iws_pkg::OPC_W-1:0]     opcode;
    logic [iws_pkg::TIME_BITS-1:0] time_now;

    modport source (output valid, output opcode, output time_now, input ready);
    modport sink   (input valid, input opcode, input time_now, output ready);
endinterface

interface iws_out_if;
    logic                          valid;
    logic                          ready;
    logic                          has_data;
    logic [iws_pkg::CNT_W-1:0]     sample_count;
    logic [iws_pkg::TIME_BITS-1:0] avg_ticks;
    logic [iws_pkg::TIME_BITS-1:0] min_ticks;
    logic [iws_pkg::TIME_BITS-1:0] max_ticks;

    modport source (output valid, output has_data, output sample_count, output avg_ticks,
                    output min_ticks, output max_ticks, input ready);
    modport sink   (input valid, input has_data, input sample_count, input avg_ticks,
                    input min_ticks, input max_ticks, output ready);
endinterface

FILE: rtl/core/iws_sample_ram.sv
module iws_sample_ram (
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [iws_pkg::PTR_W-1:0]     wr_addr,
    input  logic [iws_pkg::TIME_BITS-1:0] wr_data,
    input  logic                          rd_en,
    input  logic [iws_pkg::PTR_W-1:0]     rd_addr,
    output logic [iws_pkg::TIME_BITS-1:0] rd_data
);

    logic [iws_pkg::TIME_BITS-1:0] mem [iws_pkg::WINDOW_MAX];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: rtl/core/iws_divider.sv
module iws_divider (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [iws_pkg::SUM_W-1:0]     dividend,
    input  logic [iws_pkg::CNT_W-1:0]     divisor,
    output iws_pkg::div_stat_t            status,
    output logic [iws_pkg::TIME_BITS-1:0] quotient
);

    // Restoring division, one quotient bit per cycle, MSB first.
    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    logic [iws_pkg::DCNT_W-1:0]   cnt_reg, cnt_next;
    logic [iws_pkg::CNT_W-1:0]    rem_reg, rem_next;
    logic [iws_pkg::SUM_W-1:0]    quo_reg, quo_next;
    logic [iws_pkg::CNT_W-1:0]    div_reg, div_next;
    logic [iws_pkg::CNT_W:0]      trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        trial     = {rem_reg, quo_reg[iws_pkg::SUM_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = iws_pkg::DCNT_W'(iws_pkg::SUM_W - 1);
            rem_next  = '0;
            quo_next  = dividend;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = iws_pkg::CNT_W'(trial - {1'b0, div_reg});
                quo_next = {quo_reg[iws_pkg::SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[iws_pkg::CNT_W-1:0];
                quo_next = {quo_reg[iws_pkg::SUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            quo_reg  <= '0;
            div_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
            div_reg  <= div_next;
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    // The mean never exceeds the largest sample, so the upper bits are zero.
    assign quotient    = quo_reg[iws_pkg::TIME_BITS-1:0];

endmodule

FILE: rtl/core/interval_window_statistics.sv
// Channel   Role   Beat contents
// -------   ----   ------------------------------------------------------------
// in_ch     sink   opcode, time_now (one event)
// out_ch    source has_data, sample_count, avg_ticks, min_ticks, max_ticks
// APB       slave  window_len at byte address 0; the user writes it only while idle, not enforced
//
// A start or an unused opcode is done on acceptance; a query scans the n samples held (1 to 64)
// and divides, a stop stores its sample first, and an empty query skips scan and divide. Min and
// max come one sample per cycle from the read port of the simple dual-port sample memory, and the
// mean from a serial divider that makes one quotient bit per cycle from the 38-bit sum.
// rst_n is asynchronous, active low; it empties the window, zeroes the start time and sets
// window_len to 64. A result waits in the output register; only the next report stalls on it.
module interval_window_statistics (
    input  logic                        clk,
    input  logic                        rst_n,
    iws_in_if.sink                      in_ch,
    iws_out_if.source                   out_ch,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [iws_pkg::ADDR_W-1:0]  paddr,
    input  logic [iws_pkg::DATA_W-1:0]  pwdata,
    output logic [iws_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVICT,
        S_REPORT,
        S_SCAN,
        S_LAST,
        S_DIV,
        S_OUT
    } state_t;

    localparam int TB = iws_pkg::TIME_BITS;
    localparam int PW = iws_pkg::PTR_W;
    localparam int CW = iws_pkg::CNT_W;

    state_t                      state_reg, state_next;
    logic [CW-1:0]               wlen_reg, wlen_next;
    logic [TB-1:0]               start_reg, start_next;
    logic [PW-1:0]               wp_reg, wp_next;
    logic [CW-1:0]               fill_reg, fill_next;
    logic [iws_pkg::SUM_W-1:0]   sum_reg, sum_next;
    logic [TB-1:0]               dur_reg, dur_next;
    logic                        evict_reg, evict_next;
    logic [CW-1:0]               k_reg, k_next;
    logic                        scan_vld_reg, scan_vld_next;
    logic [TB-1:0]               min_reg, min_next;
    logic [TB-1:0]               max_reg, max_next;
    logic [TB-1:0]               avg_reg, avg_next;
    logic                        ovld_reg, ovld_next;
    logic                        ohas_reg, ohas_next;
    logic [CW-1:0]               ocnt_reg, ocnt_next;
    logic [TB-1:0]               oavg_reg, oavg_next;
    logic [TB-1:0]               omin_reg, omin_next;
    logic [TB-1:0]               omax_reg, omax_next;

    logic [CW-1:0]               eff_len;
    logic                        cfg_wr;
    logic                        ram_we;
    logic                        ram_re;
    logic [PW-1:0]               ram_raddr;
    logic [TB-1:0]               ram_rdata;
    logic                        div_start;
    iws_pkg::div_stat_t          div_stat;
    logic [TB-1:0]               div_quo;

    iws_sample_ram u_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (wp_reg),
        .wr_data (dur_reg),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    iws_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (fill_reg),
        .status   (div_stat),
        .quotient (div_quo)
    );

    // A window length of zero means one sample; anything above the memory
    // depth saturates to the full memory.
    always_comb
    begin
        if (wlen_reg == '0)
        begin
            eff_len = CW'(1);
        end
        else if (wlen_reg > CW'(iws_pkg::WINDOW_MAX))
        begin
            eff_len = CW'(iws_pkg::WINDOW_MAX);
        end
        else
        begin
            eff_len = wlen_reg;
        end
    end

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite &&
                    (paddr[iws_pkg::ADDR_W-1:2] == iws_pkg::REG_WINDOW_LEN);
    assign prdata = (paddr[iws_pkg::ADDR_W-1:2] == iws_pkg::REG_WINDOW_LEN) ?
                    iws_pkg::DATA_W'(wlen_reg) : '0;

    assign in_ch.ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        wlen_next     = wlen_reg;
        start_next    = start_reg;
        wp_next       = wp_reg;
        fill_next     = fill_reg;
        sum_next      = sum_reg;
        dur_next      = dur_reg;
        evict_next    = evict_reg;
        k_next        = k_reg;
        scan_vld_next = 1'b0;
        min_next      = min_reg;
        max_next      = max_reg;
        avg_next      = avg_reg;
        ohas_next     = ohas_reg;
        ocnt_next     = ocnt_reg;
        oavg_next     = oavg_reg;
        omin_next     = omin_reg;
        omax_next     = omax_reg;
        ovld_next     = ovld_reg && !out_ch.ready;
        ram_we        = 1'b0;
        ram_re        = 1'b0;
        ram_raddr     = wp_reg - eff_len[PW-1:0];
        div_start     = 1'b0;

        // Writing the window length empties the window; the start time stays.
        if (cfg_wr)
        begin
            wlen_next = pwdata[CW-1:0];
            wp_next   = '0;
            fill_next = '0;
            sum_next  = '0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    case (in_ch.opcode)
                        iws_pkg::OP_START:
                        begin
                            start_next = in_ch.time_now;
                        end
                        iws_pkg::OP_STOP:
                        begin
                            // Fetch the sample that falls out of a full window.
                            dur_next   = in_ch.time_now - start_reg;
                            evict_next = (fill_reg >= eff_len);
                            ram_re     = 1'b1;
                            state_next = S_EVICT;
                        end
                        iws_pkg::OP_QUERY:
                        begin
                            state_next = S_REPORT;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_EVICT:
            begin
                ram_we = 1'b1;
                wp_next = wp_reg + 1'b1;
                if (evict_reg)
                begin
                    sum_next  = sum_reg - iws_pkg::SUM_W'(ram_rdata)
                                + iws_pkg::SUM_W'(dur_reg);
                    fill_next = eff_len;
                end
                else
                begin
                    sum_next  = sum_reg + iws_pkg::SUM_W'(dur_reg);
                    fill_next = fill_reg + 1'b1;
                end
                state_next = S_REPORT;
            end
            S_REPORT:
            begin
                k_next   = CW'(1);
                min_next = '1;
                max_next = '0;
                avg_next = '0;
                if (fill_reg == '0)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // Walk back from the newest sample; read data arrives in the next cycle.
                ram_re        = 1'b1;
                ram_raddr     = wp_reg - k_reg[PW-1:0];
                scan_vld_next = 1'b1;
                if (scan_vld_reg)
                begin
                    if (ram_rdata < min_reg)
                    begin
                        min_next = ram_rdata;
                    end
                    if (ram_rdata > max_reg)
                    begin
                        max_next = ram_rdata;
                    end
                end
                if (k_reg == fill_reg)
                begin
                    state_next = S_LAST;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            S_LAST:
            begin
                if (ram_rdata < min_reg)
                begin
                    min_next = ram_rdata;
                end
                if (ram_rdata > max_reg)
                begin
                    max_next = ram_rdata;
                end
                div_start  = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_stat.done)
                begin
                    avg_next   = div_quo;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!ovld_reg || out_ch.ready)
                begin
                    ovld_next  = 1'b1;
                    ohas_next  = (fill_reg != '0);
                    ocnt_next  = fill_reg;
                    oavg_next  = avg_reg;
                    omin_next  = (fill_reg != '0) ? min_reg : '0;
                    omax_next  = max_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            wlen_reg     <= iws_pkg::WINDOW_LEN_RESET;
            start_reg    <= '0;
            wp_reg       <= '0;
            fill_reg     <= '0;
            sum_reg      <= '0;
            dur_reg      <= '0;
            evict_reg    <= 1'b0;
            k_reg        <= '0;
            scan_vld_reg <= 1'b0;
            min_reg      <= '0;
            max_reg      <= '0;
            avg_reg      <= '0;
            ovld_reg     <= 1'b0;
            ohas_reg     <= 1'b0;
            ocnt_reg     <= '0;
            oavg_reg     <= '0;
            omin_reg     <= '0;
            omax_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            wlen_reg     <= wlen_next;
            start_reg    <= start_next;
            wp_reg       <= wp_next;
            fill_reg     <= fill_next;
            sum_reg      <= sum_next;
            dur_reg      <= dur_next;
            evict_reg    <= evict_next;
            k_reg        <= k_next;
            scan_vld_reg <= scan_vld_next;
            min_reg      <= min_next;
            max_reg      <= max_next;
            avg_reg      <= avg_next;
            ovld_reg     <= ovld_next;
            ohas_reg     <= ohas_next;
            ocnt_reg     <= ocnt_next;
            oavg_reg     <= oavg_next;
            omin_reg     <= omin_next;
            omax_reg     <= omax_next;
        end
    end

    assign out_ch.valid        = ovld_reg;
    assign out_ch.has_data     = ohas_reg;
    assign out_ch.sample_count = ocnt_reg;
    assign out_ch.avg_ticks    = oavg_reg;
    assign out_ch.min_ticks    = omin_reg;
    assign out_ch.max_ticks    = omax_reg;

endmodule

FILE: rtl/core/iws_checker.sv
module iws_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic [iws_pkg::OPC_W-1:0]     in_opcode,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic                          has_data,
    input  logic [iws_pkg::CNT_W-1:0]     sample_count,
    input  logic [iws_pkg::TIME_BITS-1:0] avg_ticks,
    input  logic [iws_pkg::TIME_BITS-1:0] min_ticks,
    input  logic [iws_pkg::TIME_BITS-1:0] max_ticks
);

    // A pending result is not withdrawn before it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat dropped before it was taken");

    // has_data agrees with the count, and an empty window reports zeros.
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (has_data == (sample_count != '0)) &&
                      (has_data || (avg_ticks == '0 && min_ticks == '0 &&
                                    max_ticks == '0)))
        else $error("empty window reported inconsistently");

    // The mean lies between the minimum and the maximum.
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && has_data |-> min_ticks <= avg_ticks && avg_ticks <= max_ticks)
        else $error("min, mean and max out of order");

    // The window never reports more samples than the memory holds.
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> sample_count <= iws_pkg::CNT_W'(iws_pkg::WINDOW_MAX))
        else $error("sample count above window depth");

    // A stop or query keeps the block busy for the following cycle.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready &&
        (in_opcode == iws_pkg::OP_STOP || in_opcode == iws_pkg::OP_QUERY)
        |=> !in_ready)
        else $error("event accepted while a report was in progress");

endmodule

bind interval_window_statistics iws_checker u_iws_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .in_opcode    (in_ch.opcode),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .has_data     (out_ch.has_data),
    .sample_count (out_ch.sample_count),
    .avg_ticks    (out_ch.avg_ticks),
    .min_ticks    (out_ch.min_ticks),
    .max_ticks    (out_ch.max_ticks)
);
